[src/ortl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the ordered route table lookup block.
// No dependencies; imported by the front and back ends, core, checker and testbench.
package ortl_pkg;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_LOCKED  = 2'd2;
	localparam logic [1:0] ST_NOENTRY = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] lookup_addr;
		logic [31:0] route_net;
		logic [31:0] route_mask;
		logic [31:0] route_next_hop;
		logic        route_direct;
		logic [3:0]  remove_pos;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] next_hop;
		logic [1:0]  status;
		logic [4:0]  entry_count;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_ADD,
		OP_REMOVE,
		OP_NONE
	} op_kind_t;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] hop;
		logic        direct;
	} route_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [31:0] addr;
		route_t      route;
		logic [3:0]  rpos;
	} op_t;

endpackage

[src/ortl_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one item of payload type T.
// No dependencies; the payload type is chosen where the interface is instantiated.
interface ortl_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/ortl_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request items and classifies them into table operations.
// Depends on ortl_pkg and ortl_chan_if.
module ortl_front (
	ortl_chan_if.sink        req,
	output ortl_pkg::op_t    op,
	output logic             op_valid,
	input  logic             op_ready
);
	import ortl_pkg::*;

	assign req.ready = op_ready;
	assign op_valid  = req.valid;

	always_comb begin
		op.addr         = req.data.lookup_addr;
		op.rpos         = req.data.remove_pos;
		op.route.net    = req.data.route_net;
		op.route.mask   = req.data.route_mask;
		op.route.direct = req.data.route_direct;
		op.route.hop    = req.data.route_direct ? 32'd0 : req.data.route_next_hop;
		unique case (req.data.cmd)
			CMD_LOOKUP: op.kind = OP_LOOKUP;
			CMD_ADD:    op.kind = OP_ADD;
			CMD_REMOVE: op.kind = OP_REMOVE;
			default:    op.kind = OP_NONE;
		endcase
	end
endmodule

[src/ortl_queue.sv]
`timescale 1ns / 1ps
// Short FIFO between the front end and the back end.
// Depends on nothing; element type and depth are parameters.
module ortl_queue #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  T     push_data,
	input  logic push_valid,
	output logic push_ready,
	output T     pop_data,
	output logic pop_valid,
	input  logic pop_ready
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	T                slot_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = fill_q != CNTW'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end
endmodule

[src/ortl_back.sv]
`timescale 1ns / 1ps
// Back end: route table cells, per-entry compares, ordered insert and remove.
// Depends on ortl_pkg and ortl_chan_if.
module ortl_back #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ortl_pkg::op_t  op,
	input  logic           op_valid,
	output logic           op_ready,
	ortl_chan_if.source    rsp
);
	import ortl_pkg::*;

	localparam int D  = TABLE_DEPTH;
	localparam int CW = $clog2(D + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	typedef enum logic {ST_PICK, ST_APPLY} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            out_v_q;
	out_item_t       out_q;
	route_t          tbl_q [D];

	op_t             op_s1;
	logic [D-1:0]    match_s1;
	logic [D-1:0]    cand_s1;
	logic [D-1:0]    live_s1;

	logic [D-1:0]    live;
	logic [D-1:0]    match;
	logic [D-1:0]    cand;
	logic [D-1:0]    first_hit;
	logic [D-1:0]    first_cand;
	logic [D-1:0]    ge_ins;
	logic [D-1:0]    ge_rm;
	logic [D-1:0]    rsel;
	logic [D-1:0]    dir_vec;
	logic [31:0]     nh;
	logic            full;
	logic            rpos_ok;
	logic            rpos_direct;
	logic            apply;
	logic            wr_ins;
	logic            wr_rm;
	logic [CW-1:0]   count_d;
	out_item_t       res;
	route_t          tbl_d [D];

	assign op_ready  = (state_q == ST_PICK);
	assign apply     = (state_q == ST_APPLY) && (!out_v_q || rsp.ready);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	always_comb begin
		for (int i = 0; i < D; i++) begin
			live[i]    = CW'(i) < count_q;
			match[i]   = live[i] && ((tbl_q[i].mask & op.addr) == tbl_q[i].net);
			cand[i]    = live[i] && !tbl_q[i].direct && (tbl_q[i].mask <= op.route.mask);
			dir_vec[i] = tbl_q[i].direct;
			rsel[i]    = PW'(i) == PW'(op_s1.rpos);
			ge_rm[i]   = PW'(i) >= PW'(op_s1.rpos);
		end
	end

	always_comb begin
		first_hit  = match_s1 & (~match_s1 + 1'b1);
		first_cand = cand_s1 & (~cand_s1 + 1'b1);
		nh = '0;
		for (int i = 0; i < D; i++)
			nh = nh | (first_hit[i] ? tbl_q[i].hop : 32'd0);
		if (op_s1.route.direct)
			ge_ins = '1;
		else if (|cand_s1)
			ge_ins = ~(first_cand - 1'b1);
		else
			ge_ins = ~live_s1;
		full        = count_q == CW'(D);
		rpos_ok     = PW'(op_s1.rpos) < PW'(count_q);
		rpos_direct = |(rsel & dir_vec);
	end

	always_comb begin
		res     = '0;
		count_d = count_q;
		wr_ins  = 1'b0;
		wr_rm   = 1'b0;
		unique case (op_s1.kind)
			OP_LOOKUP: begin
				res.hit      = |match_s1;
				res.next_hop = nh;
			end
			OP_ADD: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					wr_ins  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!rpos_ok) begin
					res.status = ST_NOENTRY;
				end else if (rpos_direct) begin
					res.status = ST_LOCKED;
				end else begin
					wr_rm   = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			default: ;
		endcase
		res.entry_count = 5'(count_d);
	end

	always_comb begin
		for (int i = 0; i < D; i++) begin
			tbl_d[i] = tbl_q[i];
			if (wr_ins) begin
				if (ge_ins[i] && (i == 0 || !ge_ins[(i == 0) ? 0 : i - 1]))
					tbl_d[i] = op_s1.route;
				else if (ge_ins[i])
					tbl_d[i] = tbl_q[(i == 0) ? 0 : i - 1];
			end else if (wr_rm) begin
				if (ge_rm[i] && i < D - 1)
					tbl_d[i] = tbl_q[(i == D - 1) ? i : i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PICK;
			count_q <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (apply)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_PICK: begin
					if (op_valid)
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply) begin
						state_q <= ST_PICK;
						count_q <= count_d;
						out_q   <= res;
					end
				end
				default: state_q <= ST_PICK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_ready && op_valid) begin
			op_s1    <= op;
			match_s1 <= match;
			cand_s1  <= cand;
			live_s1  <= live;
		end
		if (apply)
			tbl_q <= tbl_d;
	end
endmodule

[src/ordered_route_table_lookup_core.sv]
`timescale 1ns / 1ps
// Ordered route table: first-match lookup, ordered add, remove by position.
// A request passes the queue, the compare registers and the apply step, which
// waits on rsp; the back end takes a new operation only once the last is applied.
// A 2-entry queue lets requests be taken while a result waits on rsp.
// Reset clears the route count, the queue and the result register; no clearing pass.
module ordered_route_table_lookup_core #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ortl_chan_if.sink   req,
	ortl_chan_if.source rsp
);
	import ortl_pkg::*;

	op_t  fe_op;
	logic fe_valid;
	logic fe_ready;
	op_t  be_op;
	logic be_valid;
	logic be_ready;

	ortl_front u_front (
		.req      (req),
		.op       (fe_op),
		.op_valid (fe_valid),
		.op_ready (fe_ready)
	);

	ortl_queue #(.T(op_t), .DEPTH(2)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fe_op),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.pop_data   (be_op),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready)
	);

	ortl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (be_op),
		.op_valid (be_valid),
		.op_ready (be_ready),
		.rsp      (rsp)
	);
endmodule

[src/ortl_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result channel of the route table core.
// Depends on ortl_pkg; bound to ordered_route_table_lookup_core below.
module ortl_checker #(
	parameter int TABLE_DEPTH = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input ortl_pkg::out_item_t out_data
);
	import ortl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.next_hop == 32'd0)
		else $error("miss with nonzero next hop");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.status == ST_OK)
		else $error("hit with error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.entry_count == 5'(TABLE_DEPTH))
		else $error("full status with table not full");
endmodule

bind ordered_route_table_lookup_core ortl_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);

[tb/sv/ordered_route_table_lookup_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ordered route table: directed and random
// lookup/add/remove and unused-command traffic with a predicting scoreboard.
// Depends on ortl_pkg, ortl_chan_if and ordered_route_table_lookup_core.
import ortl_pkg::*;

localparam int unsigned ROUTE_SLOTS = 16;
localparam logic [1:0]  CMD_UNUSED  = 2'd3;

class route_table_model;
	route_t      slots[ROUTE_SLOTS];
	int unsigned n_routes;
	out_item_t   expected_replies[$];
	int unsigned mismatches;

	function new();
		n_routes = 0;
		mismatches = 0;
	endfunction

	function int unsigned direct_count();
		int unsigned c;
		c = 0;
		for (int i = 0; i < n_routes; i++)
			if (slots[i].direct) c++;
		return c;
	endfunction

	function void note_request(in_item_t it);
		out_item_t   r;
		int unsigned pos;
		bit          found;
		r = '0;
		found = 1'b0;
		case (it.cmd)
		CMD_LOOKUP: begin
			for (int i = 0; i < n_routes; i++) begin
				if (!found && (slots[i].mask & it.lookup_addr) == slots[i].net) begin
					found = 1'b1;
					r.hit = 1'b1;
					r.next_hop = slots[i].hop;
				end
			end
		end
		CMD_ADD: begin
			if (n_routes >= ROUTE_SLOTS) begin
				r.status = ST_FULL;
			end else begin
				pos = n_routes;
				if (it.route_direct) begin
					pos = 0;
				end else begin
					for (int i = 0; i < n_routes; i++) begin
						if (!found && !slots[i].direct && slots[i].mask <= it.route_mask) begin
							found = 1'b1;
							pos = i;
						end
					end
				end
				for (int i = n_routes; i > pos; i--)
					slots[i] = slots[i - 1];
				slots[pos].net = it.route_net;
				slots[pos].mask = it.route_mask;
				slots[pos].hop = it.route_direct ? 32'h0 : it.route_next_hop;
				slots[pos].direct = it.route_direct;
				n_routes++;
			end
		end
		CMD_REMOVE: begin
			if (it.remove_pos >= n_routes) begin
				r.status = ST_NOENTRY;
			end else if (slots[it.remove_pos].direct) begin
				r.status = ST_LOCKED;
			end else begin
				for (int i = it.remove_pos; i + 1 < n_routes; i++)
					slots[i] = slots[i + 1];
				n_routes--;
			end
		end
		default: begin
		end
		endcase
		r.entry_count = 5'(n_routes);
		expected_replies.push_back(r);
	endfunction

	function void check_reply(out_item_t got);
		out_item_t want;
		if (expected_replies.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected reply: hit=%0d next_hop=%h status=%0d count=%0d",
					got.hit, got.next_hop, got.status, got.entry_count);
			return;
		end
		want = expected_replies.pop_front();
		if (got.hit !== want.hit || got.next_hop !== want.next_hop ||
				got.status !== want.status || got.entry_count !== want.entry_count) begin
			mismatches++;
			if (mismatches <= 10)
				$display("reply mismatch: expected hit=%0d next_hop=%h status=%0d count=%0d, got hit=%0d next_hop=%h status=%0d count=%0d",
					want.hit, want.next_hop, want.status, want.entry_count,
					got.hit, got.next_hop, got.status, got.entry_count);
		end
	endfunction
endclass

module ordered_route_table_lookup_core_test;
	localparam int          RANDOM_ITEMS = 550;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic             clk;
	logic             arst_n;
	int unsigned      cycle_count;
	int unsigned      send_idle_pct;
	int unsigned      sink_stall_pct;
	route_table_model table_model;

	int unsigned idle_by_phase[4]  = '{0, 65, 0, 21};
	int unsigned stall_by_phase[4] = '{0, 0, 65, 21};

	ortl_chan_if #(.T(in_item_t))  req_ch ();
	ortl_chan_if #(.T(out_item_t)) rsp_ch ();

	ordered_route_table_lookup_core #(
		.TABLE_DEPTH(ROUTE_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				table_model.check_reply(rsp_ch.data);
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	function automatic in_item_t request(logic [1:0] cmd, logic [31:0] addr, logic [31:0] net,
			logic [31:0] mask, logic [31:0] hop, logic direct, logic [3:0] pos);
		in_item_t it;
		it.cmd = cmd;
		it.lookup_addr = addr;
		it.route_net = net;
		it.route_mask = mask;
		it.route_next_hop = hop;
		it.route_direct = direct;
		it.remove_pos = pos;
		return it;
	endfunction

	function automatic in_item_t make_random(bit grow);
		in_item_t    it;
		int unsigned sel;
		int unsigned plen;
		int unsigned k;
		int unsigned n;
		n = table_model.n_routes;
		it = request(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
			1'($urandom_range(1)), 4'($urandom_range(15)));
		sel = $urandom_range(99);
		if (sel < (grow ? 50 : 12)) begin
			it.cmd = CMD_ADD;
			if ($urandom_range(99) >= 10) begin
				plen = $urandom_range(32);
				it.route_mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
			end
			if ($urandom_range(99) < 75)
				it.route_net = it.route_net & it.route_mask;
			it.route_direct = (table_model.direct_count() < 4) && ($urandom_range(99) < 3);
		end else if (sel < (grow ? 60 : 55)) begin
			it.cmd = CMD_REMOVE;
			if (n > 0 && $urandom_range(99) < 85)
				it.remove_pos = 4'($urandom_range(n - 1));
		end else if (sel < 95) begin
			it.cmd = CMD_LOOKUP;
			if (n > 0 && $urandom_range(99) < 80) begin
				k = $urandom_range(n - 1);
				it.lookup_addr = table_model.slots[k].net | ($urandom & ~table_model.slots[k].mask);
			end
		end else begin
			it.cmd = CMD_UNUSED;
		end
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		table_model.note_request(it);
	endtask

	initial begin
		int phase;
		table_model = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(request(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1, 4'hF));
		send_item(request(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'h0A00_0000, 32'hFF00_0000, 32'hDEAD_BEEF, 1'b1, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0001, 1'b0, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0002, 1'b0, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'hC0A8_0180, 32'hFFFF_FF00, 32'h0A00_0003, 1'b0, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 4'd0));
		send_item(request(CMD_LOOKUP, 32'hC0A8_0105, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_LOOKUP, 32'hC0A8_0185, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd15));
		send_item(request(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd1));
		send_item(request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_ADD, 32'h0, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'h0, 1'b1, 4'd0));
		send_item(request(CMD_LOOKUP, 32'hC0A8_0101, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));
		send_item(request(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd6));
		send_item(request(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd5));
		send_item(request(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 4'd0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			phase = n * 4 / RANDOM_ITEMS;
			send_idle_pct = idle_by_phase[phase];
			sink_stall_pct = stall_by_phase[phase];
			send_item(make_random(((n / 40) % 2) == 0));
		end
		req_ch.valid <= 1'b0;

		while (table_model.expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (table_model.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

[sim.f]
src/ortl_pkg.sv
src/ortl_chan_if.sv
src/ortl_front.sv
src/ortl_queue.sv
src/ortl_back.sv
src/ordered_route_table_lookup_core.sv
src/ortl_checker.sv
tb/sv/ordered_route_table_lookup_core_test.sv
